@@ src/rdu_pkg.sv @@
// Types, widths and helpers shared by the refraction direction unit.
// Depends on nothing; refraction_direction_unit imports it.
package rdu_pkg;

  localparam int VW        = 16;
  localparam int VFRAC     = VW - 2;
  localparam int QI        = 24;
  localparam int VQ_W      = QI + 3;
  localparam int IDX_W     = 15;

  localparam int LOAD_UP   = (VFRAC <= QI) ? (QI - VFRAC) : 0;
  localparam int LOAD_DN   = (VFRAC > QI) ? (VFRAC - QI) : 0;
  localparam int LOAD_HALF = (LOAD_DN > 0) ? (1 << (LOAD_DN - 1)) : 0;

  localparam int NR_Q_W    = QI + 4;
  localparam int NR_W      = NR_Q_W;
  localparam int NRNUM_W   = IDX_W + QI + 1;
  localparam logic [NR_W-1:0] NR_MAX = NR_W'(8) << QI;

  localparam int PROD_W    = 2 * VQ_W;
  localparam int DOT_W     = PROD_W + 2;
  localparam int COS_W     = QI + 6;
  localparam int CC_W      = 2 * COS_W;
  localparam int SIN_W     = QI + 10;
  localparam int NR2P_W    = 2 * NR_W;
  localparam int NR2_W     = NR2P_W - QI;
  localparam int NCP_W     = NR_W + 1 + COS_W;
  localparam int NC_W      = QI + 9;
  localparam int PR_W      = NR2_W + 1 + SIN_W;
  localparam int C2_W      = QI + 16;
  localparam int ARG_W     = 64;
  localparam int ROOT_W    = ARG_W / 2;
  localparam int K_W       = ROOT_W + 3;
  localparam int KN_W      = K_W + VQ_W;
  localparam int ND_W      = NR_W + 1 + VQ_W;
  localparam int TS_W      = KN_W + 1;
  localparam int T_W       = QI + 13;
  localparam int MAG_W     = T_W - 1;
  localparam int NL_W      = 30;
  localparam int SQ_W      = 2 * NL_W;
  localparam int LEN2_W    = SQ_W + 2;
  localparam int LDEN_W    = ROOT_W + 1;
  localparam int OQ_W      = VFRAC + 1;
  localparam int ONUM_W    = NL_W + OQ_W + 1;

  localparam logic [1:0] ST_REFRACTED  = 2'd0;
  localparam logic [1:0] ST_TIR        = 2'd1;
  localparam logic [1:0] ST_DEGENERATE = 2'd2;

  typedef struct packed {
    logic signed [VW-1:0] normal_x;
    logic signed [VW-1:0] normal_y;
    logic signed [VW-1:0] normal_z;
    logic signed [VW-1:0] incoming_x;
    logic signed [VW-1:0] incoming_y;
    logic signed [VW-1:0] incoming_z;
    logic [IDX_W-1:0]     index_incident;
    logic [IDX_W-1:0]     index_transmitted;
  } rdu_in_t;

  typedef struct packed {
    logic signed [VW-1:0] refracted_x;
    logic signed [VW-1:0] refracted_y;
    logic signed [VW-1:0] refracted_z;
    logic [1:0]           refract_status;
  } rdu_out_t;

  typedef struct packed {
    logic [2:0][VQ_W-1:0] n;
    logic [2:0][VQ_W-1:0] d;
    logic [COS_W-1:0]     cosi;
    logic [SIN_W-1:0]     sin2;
    logic                 sat;
  } pay_a_t;

  typedef struct packed {
    logic [2:0][VQ_W-1:0] n;
    logic [2:0][VQ_W-1:0] d;
    logic [NR_W-1:0]      nr;
    logic [NC_W-1:0]      nc;
    logic                 tir;
  } pay_b_t;

  typedef struct packed {
    logic [2:0][NL_W-1:0] mag;
    logic [2:0]           neg;
    logic                 tir;
  } pay_c_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       tir;
    logic       zero;
  } pay_d_t;

  function automatic logic [VQ_W-1:0] load_vec(input logic [VW-1:0] raw);
    logic signed [VW+QI:0] wide;
    wide = $signed({{(QI + 1){raw[VW-1]}}, raw});
    wide = wide <<< LOAD_UP;
    wide = wide + (VW + QI + 1)'(LOAD_HALF);
    wide = wide >>> LOAD_DN;
    return wide[VQ_W-1:0];
  endfunction

endpackage

@@ src/rdu_div_pipe.sv @@
// Pipelined restoring divider, STEPS quotient bits per stage, shared divisor.
// Depends on nothing beyond its parameters.
module rdu_div_pipe #(
  parameter int LANES = 1,
  parameter int NUM_W = 40,
  parameter int DEN_W = 15,
  parameter int Q_W   = 28,
  parameter int STEPS = 4,
  parameter int PAY_W = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [LANES-1:0][NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0]            in_den,
  input  logic [PAY_W-1:0]            in_pay,
  output logic                        out_vld,
  output logic [LANES-1:0][Q_W-1:0]   out_q,
  output logic [PAY_W-1:0]            out_pay
);
  localparam int WK_W   = DEN_W + Q_W;
  localparam int STAGES = (Q_W + STEPS - 1) / STEPS;

  logic                       vld_in  [STAGES];
  logic [LANES-1:0][WK_W-1:0] wk_in   [STAGES];
  logic [DEN_W-1:0]           den_in  [STAGES];
  logic [PAY_W-1:0]           pay_in  [STAGES];
  logic [LANES-1:0][WK_W-1:0] wk_nxt  [STAGES];
  logic                       vld_r   [STAGES];
  logic [LANES-1:0][WK_W-1:0] wk_r    [STAGES];
  logic [DEN_W-1:0]           den_r   [STAGES];
  logic [PAY_W-1:0]           pay_r   [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          wk_in[0][l] = WK_W'(in_num[l]);
        end
      end
      assign vld_in[0] = in_vld;
      assign den_in[0] = in_den;
      assign pay_in[0] = in_pay;
    end else begin : g_next
      assign wk_in[s]  = wk_r[s-1];
      assign vld_in[s] = vld_r[s-1];
      assign den_in[s] = den_r[s-1];
      assign pay_in[s] = pay_r[s-1];
    end

    always_comb begin
      logic [DEN_W-1:0] rem;
      logic [Q_W-1:0]   low;
      logic [DEN_W:0]   r2;
      for (int l = 0; l < LANES; l++) begin
        rem = wk_in[s][l][WK_W-1:Q_W];
        low = wk_in[s][l][Q_W-1:0];
        for (int j = 0; j < STEPS; j++) begin
          if (s * STEPS + j < Q_W) begin
            r2  = {rem, low[Q_W-1]};
            low = {low[Q_W-2:0], 1'b0};
            if (r2 >= {1'b0, den_in[s]}) begin
              r2     = r2 - {1'b0, den_in[s]};
              low[0] = 1'b1;
            end
            rem = r2[DEN_W-1:0];
          end
        end
        wk_nxt[s][l] = {rem, low};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        wk_r[s]  <= wk_nxt[s];
        den_r[s] <= den_in[s];
        pay_r[s] <= pay_in[s];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_q[l] = wk_r[STAGES-1][l][Q_W-1:0];
    end
  end
  assign out_vld = vld_r[STAGES-1];
  assign out_pay = pay_r[STAGES-1];

endmodule

@@ src/rdu_sqrt_pipe.sv @@
// Pipelined digit-by-digit integer square root, floor of the root.
// Depends on nothing beyond its parameters.
module rdu_sqrt_pipe #(
  parameter int ARG_W = 64,
  parameter int STEPS = 4,
  parameter int PAY_W = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [ARG_W-1:0]     in_arg,
  input  logic [PAY_W-1:0]     in_pay,
  output logic                 out_vld,
  output logic [ARG_W/2-1:0]   out_root,
  output logic [PAY_W-1:0]     out_pay
);
  localparam int R_W    = ARG_W / 2;
  localparam int STAGES = (R_W + STEPS - 1) / STEPS;

  logic             vld_in   [STAGES];
  logic [ARG_W-1:0] arg_in   [STAGES];
  logic [R_W+1:0]   rem_in   [STAGES];
  logic [R_W-1:0]   root_in  [STAGES];
  logic [PAY_W-1:0] pay_in   [STAGES];
  logic [ARG_W-1:0] arg_nxt  [STAGES];
  logic [R_W+1:0]   rem_nxt  [STAGES];
  logic [R_W-1:0]   root_nxt [STAGES];
  logic             vld_r    [STAGES];
  logic [ARG_W-1:0] arg_r    [STAGES];
  logic [R_W+1:0]   rem_r    [STAGES];
  logic [R_W-1:0]   root_r   [STAGES];
  logic [PAY_W-1:0] pay_r    [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign vld_in[0]  = in_vld;
      assign arg_in[0]  = in_arg;
      assign rem_in[0]  = '0;
      assign root_in[0] = '0;
      assign pay_in[0]  = in_pay;
    end else begin : g_next
      assign vld_in[s]  = vld_r[s-1];
      assign arg_in[s]  = arg_r[s-1];
      assign rem_in[s]  = rem_r[s-1];
      assign root_in[s] = root_r[s-1];
      assign pay_in[s]  = pay_r[s-1];
    end

    always_comb begin
      logic [R_W+3:0]   rem4;
      logic [R_W+3:0]   trial;
      logic [R_W+1:0]   rem;
      logic [R_W-1:0]   root;
      logic [ARG_W-1:0] arg;
      rem  = rem_in[s];
      root = root_in[s];
      arg  = arg_in[s];
      for (int j = 0; j < STEPS; j++) begin
        if (s * STEPS + j < R_W) begin
          rem4  = {rem, arg[ARG_W-1 -: 2]};
          trial = {2'b00, root, 2'b01};
          arg   = {arg[ARG_W-3:0], 2'b00};
          if (rem4 >= trial) begin
            rem4 = rem4 - trial;
            root = {root[R_W-2:0], 1'b1};
          end else begin
            root = {root[R_W-2:0], 1'b0};
          end
          rem = rem4[R_W+1:0];
        end
      end
      rem_nxt[s]  = rem;
      root_nxt[s] = root;
      arg_nxt[s]  = arg;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        arg_r[s]  <= arg_nxt[s];
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
        pay_r[s]  <= pay_in[s];
      end
    end
  end

  assign out_vld  = vld_r[STAGES-1];
  assign out_root = root_r[STAGES-1];
  assign out_pay  = pay_r[STAGES-1];

endmodule

@@ src/refraction_direction_unit.sv @@
// Accepts one request per cycle while in_stall is low. The depth is set by the
// index-ratio divider (7 stages), two square-root pipes (8 stages each) and the
// normalizing divider (4 stages). The pipeline stalls as a whole only when the
// output holds a result, out_stall is high and the last stage is full.
// Synchronous active-low reset clears all valid bits.
module refraction_direction_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rdu_pkg::rdu_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rdu_pkg::rdu_out_t out_data
);
  import rdu_pkg::*;

  logic en;
  logic out_load;

  // stage 1: load vectors, dot product terms, ratio numerator
  logic                s1_vld_r;
  logic [2:0][VQ_W-1:0]   s1_n_r, s1_d_r, s1_n_nxt, s1_d_nxt;
  logic [2:0][PROD_W-1:0] s1_p_r, s1_p_nxt;
  logic [NRNUM_W-1:0]  s1_num_r, s1_num_nxt;
  logic [IDX_W-1:0]    s1_den_r;
  logic                s1_sat_r, s1_sat_nxt;

  always_comb begin
    s1_n_nxt[0] = load_vec(in_data.normal_x);
    s1_n_nxt[1] = load_vec(in_data.normal_y);
    s1_n_nxt[2] = load_vec(in_data.normal_z);
    s1_d_nxt[0] = load_vec(in_data.incoming_x);
    s1_d_nxt[1] = load_vec(in_data.incoming_y);
    s1_d_nxt[2] = load_vec(in_data.incoming_z);
    for (int i = 0; i < 3; i++) begin
      s1_p_nxt[i] = $signed(s1_n_nxt[i]) * $signed(s1_d_nxt[i]);
    end
    s1_num_nxt = (NRNUM_W'(in_data.index_incident) << QI)
               + NRNUM_W'(in_data.index_transmitted >> 1);
    s1_sat_nxt = (in_data.index_transmitted == '0)
              || (IDX_W'(s1_num_nxt[NRNUM_W-1:NR_Q_W]) >= in_data.index_transmitted);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_n_r   <= s1_n_nxt;
      s1_d_r   <= s1_d_nxt;
      s1_p_r   <= s1_p_nxt;
      s1_num_r <= s1_num_nxt;
      s1_den_r <= in_data.index_transmitted;
      s1_sat_r <= s1_sat_nxt;
    end
  end

  // stage 2: cosi
  logic                s2_vld_r;
  logic [2:0][VQ_W-1:0] s2_n_r, s2_d_r;
  logic [COS_W-1:0]    s2_cosi_r, s2_cosi_nxt;
  logic [NRNUM_W-1:0]  s2_num_r;
  logic [IDX_W-1:0]    s2_den_r;
  logic                s2_sat_r;

  always_comb begin
    logic signed [DOT_W-1:0] dot;
    dot = -($signed(s1_p_r[0]) + $signed(s1_p_r[1]) + $signed(s1_p_r[2]));
    dot = dot + (DOT_W'(1) << (QI - 1));
    dot = dot >>> QI;
    s2_cosi_nxt = dot[COS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_n_r    <= s1_n_r;
      s2_d_r    <= s1_d_r;
      s2_cosi_r <= s2_cosi_nxt;
      s2_num_r  <= s1_num_r;
      s2_den_r  <= s1_den_r;
      s2_sat_r  <= s1_sat_r;
    end
  end

  // stage 3: cosi squared
  logic                s3_vld_r;
  logic [2:0][VQ_W-1:0] s3_n_r, s3_d_r;
  logic [COS_W-1:0]    s3_cosi_r;
  logic [CC_W-1:0]     s3_cc_r, s3_cc_nxt;
  logic [NRNUM_W-1:0]  s3_num_r;
  logic [IDX_W-1:0]    s3_den_r;
  logic                s3_sat_r;

  assign s3_cc_nxt = $signed(s2_cosi_r) * $signed(s2_cosi_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_n_r    <= s2_n_r;
      s3_d_r    <= s2_d_r;
      s3_cosi_r <= s2_cosi_r;
      s3_cc_r   <= s3_cc_nxt;
      s3_num_r  <= s2_num_r;
      s3_den_r  <= s2_den_r;
      s3_sat_r  <= s2_sat_r;
    end
  end

  // stage 4: sin squared
  logic               s4_vld_r;
  pay_a_t             s4_pay_r, s4_pay_nxt;
  logic [NRNUM_W-1:0] s4_num_r;
  logic [IDX_W-1:0]   s4_den_r;

  always_comb begin
    logic signed [CC_W-1:0] rcc;
    rcc = s3_cc_r + (CC_W'(1) << (QI - 1));
    rcc = rcc >>> QI;
    s4_pay_nxt.n    = s3_n_r;
    s4_pay_nxt.d    = s3_d_r;
    s4_pay_nxt.cosi = s3_cosi_r;
    s4_pay_nxt.sin2 = (SIN_W'(1) << QI) - rcc[SIN_W-1:0];
    s4_pay_nxt.sat  = s3_sat_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_pay_r <= s4_pay_nxt;
      s4_num_r <= s3_num_r;
      s4_den_r <= s3_den_r;
    end
  end

  // index ratio divider
  logic                        da_vld;
  logic [0:0][NR_Q_W-1:0]      da_q;
  logic [$bits(pay_a_t)-1:0]   da_pay_raw;
  pay_a_t                      da_pay;

  rdu_div_pipe #(
    .LANES(1), .NUM_W(NRNUM_W), .DEN_W(IDX_W), .Q_W(NR_Q_W), .STEPS(4),
    .PAY_W($bits(pay_a_t))
  ) u_div_nr (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(s4_vld_r),
    .in_num(s4_num_r), .in_den(s4_den_r), .in_pay(s4_pay_r),
    .out_vld(da_vld), .out_q(da_q), .out_pay(da_pay_raw)
  );
  assign da_pay = da_pay_raw;

  // stage 5: clamp ratio
  logic                s5_vld_r;
  logic [2:0][VQ_W-1:0] s5_n_r, s5_d_r;
  logic [COS_W-1:0]    s5_cosi_r;
  logic [SIN_W-1:0]    s5_sin2_r;
  logic [NR_W-1:0]     s5_nr_r, s5_nr_nxt;

  assign s5_nr_nxt = (da_pay.sat || (da_q[0] > NR_MAX)) ? NR_MAX : da_q[0];

  always_ff @(posedge clk) begin
    if (en) begin
      s5_n_r    <= da_pay.n;
      s5_d_r    <= da_pay.d;
      s5_cosi_r <= da_pay.cosi;
      s5_sin2_r <= da_pay.sin2;
      s5_nr_r   <= s5_nr_nxt;
    end
  end

  // stage 6: nr squared, nr times cosi
  logic                s6_vld_r;
  logic [2:0][VQ_W-1:0] s6_n_r, s6_d_r;
  logic [SIN_W-1:0]    s6_sin2_r;
  logic [NR_W-1:0]     s6_nr_r;
  logic [NR2P_W-1:0]   s6_nr2p_r, s6_nr2p_nxt;
  logic [NCP_W-1:0]    s6_ncp_r, s6_ncp_nxt;

  assign s6_nr2p_nxt = NR2P_W'(s5_nr_r) * NR2P_W'(s5_nr_r);
  assign s6_ncp_nxt  = $signed({1'b0, s5_nr_r}) * $signed(s5_cosi_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s6_n_r    <= s5_n_r;
      s6_d_r    <= s5_d_r;
      s6_sin2_r <= s5_sin2_r;
      s6_nr_r   <= s5_nr_r;
      s6_nr2p_r <= s6_nr2p_nxt;
      s6_ncp_r  <= s6_ncp_nxt;
    end
  end

  // stage 7: round both products
  logic                s7_vld_r;
  logic [2:0][VQ_W-1:0] s7_n_r, s7_d_r;
  logic [SIN_W-1:0]    s7_sin2_r;
  logic [NR_W-1:0]     s7_nr_r;
  logic [NR2_W-1:0]    s7_nr2_r, s7_nr2_nxt;
  logic [NC_W-1:0]     s7_nc_r, s7_nc_nxt;

  always_comb begin
    logic [NR2P_W-1:0]       rn;
    logic signed [NCP_W-1:0] rc;
    rn = s6_nr2p_r + (NR2P_W'(1) << (QI - 1));
    rn = rn >> QI;
    rc = s6_ncp_r + (NCP_W'(1) << (QI - 1));
    rc = rc >>> QI;
    s7_nr2_nxt = rn[NR2_W-1:0];
    s7_nc_nxt  = rc[NC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_n_r    <= s6_n_r;
      s7_d_r    <= s6_d_r;
      s7_sin2_r <= s6_sin2_r;
      s7_nr_r   <= s6_nr_r;
      s7_nr2_r  <= s7_nr2_nxt;
      s7_nc_r   <= s7_nc_nxt;
    end
  end

  // stage 8: nr squared times sin squared
  logic                s8_vld_r;
  logic [2:0][VQ_W-1:0] s8_n_r, s8_d_r;
  logic [NR_W-1:0]     s8_nr_r;
  logic [NC_W-1:0]     s8_nc_r;
  logic [PR_W-1:0]     s8_pr_r, s8_pr_nxt;

  assign s8_pr_nxt = $signed({1'b0, s7_nr2_r}) * $signed(s7_sin2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s8_n_r  <= s7_n_r;
      s8_d_r  <= s7_d_r;
      s8_nr_r <= s7_nr_r;
      s8_nc_r <= s7_nc_r;
      s8_pr_r <= s8_pr_nxt;
    end
  end

  // stage 9: cos squared of the transmitted angle, total internal reflection test
  logic             s9_vld_r;
  pay_b_t           s9_pay_r, s9_pay_nxt;
  logic [ARG_W-1:0] s9_arg_r, s9_arg_nxt;

  always_comb begin
    logic signed [PR_W-1:0] rp;
    logic signed [C2_W-1:0] c2;
    rp = s8_pr_r + (PR_W'(1) << (QI - 1));
    rp = rp >>> QI;
    c2 = (C2_W'(1) << QI) - rp[C2_W-1:0];
    s9_pay_nxt.n   = s8_n_r;
    s9_pay_nxt.d   = s8_d_r;
    s9_pay_nxt.nr  = s8_nr_r;
    s9_pay_nxt.nc  = s8_nc_r;
    s9_pay_nxt.tir = c2[C2_W-1];
    s9_arg_nxt     = c2[C2_W-1] ? '0 : (ARG_W'(unsigned'(c2)) << QI);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_pay_r <= s9_pay_nxt;
      s9_arg_r <= s9_arg_nxt;
    end
  end

  // root of cos squared
  logic                      sb_vld;
  logic [ROOT_W-1:0]         sb_root;
  logic [$bits(pay_b_t)-1:0] sb_pay_raw;
  pay_b_t                    sb_pay;

  rdu_sqrt_pipe #(
    .ARG_W(ARG_W), .STEPS(4), .PAY_W($bits(pay_b_t))
  ) u_sqrt_cos (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(s9_vld_r),
    .in_arg(s9_arg_r), .in_pay(s9_pay_r),
    .out_vld(sb_vld), .out_root(sb_root), .out_pay(sb_pay_raw)
  );
  assign sb_pay = sb_pay_raw;

  // stage 10: normal coefficient
  logic                s10_vld_r;
  logic [2:0][VQ_W-1:0] s10_n_r, s10_d_r;
  logic [NR_W-1:0]     s10_nr_r;
  logic [K_W-1:0]      s10_k_r, s10_k_nxt;
  logic                s10_tir_r;

  assign s10_k_nxt = $signed(sb_pay.nc) - $signed({1'b0, sb_root});

  always_ff @(posedge clk) begin
    if (en) begin
      s10_n_r   <= sb_pay.n;
      s10_d_r   <= sb_pay.d;
      s10_nr_r  <= sb_pay.nr;
      s10_k_r   <= s10_k_nxt;
      s10_tir_r <= sb_pay.tir;
    end
  end

  // stage 11: component products
  logic                 s11_vld_r;
  logic [2:0][KN_W-1:0] s11_kn_r, s11_kn_nxt;
  logic [2:0][ND_W-1:0] s11_nd_r, s11_nd_nxt;
  logic                 s11_tir_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s11_kn_nxt[i] = $signed(s10_k_r) * $signed(s10_n_r[i]);
      s11_nd_nxt[i] = $signed({1'b0, s10_nr_r}) * $signed(s10_d_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s11_kn_r  <= s11_kn_nxt;
      s11_nd_r  <= s11_nd_nxt;
      s11_tir_r <= s10_tir_r;
    end
  end

  // stage 12: transmitted vector
  logic                s12_vld_r;
  logic [2:0][T_W-1:0] s12_t_r, s12_t_nxt;
  logic                s12_tir_r;

  always_comb begin
    logic signed [TS_W-1:0] ts;
    for (int i = 0; i < 3; i++) begin
      ts = $signed(s11_kn_r[i]) + $signed(s11_nd_r[i]);
      ts = ts + (TS_W'(1) << (QI - 1));
      ts = ts >>> QI;
      s12_t_nxt[i] = ts[T_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s12_t_r   <= s12_t_nxt;
      s12_tir_r <= s11_tir_r;
    end
  end

  // stage 13: magnitudes scaled below the norm limit
  logic                 s13_vld_r;
  logic [2:0][NL_W-1:0] s13_mag_r, s13_mag_nxt;
  logic [2:0]           s13_neg_r, s13_neg_nxt;
  logic                 s13_tir_r;

  always_comb begin
    logic [2:0][MAG_W-1:0] mag;
    logic [MAG_W-1:0]      m;
    logic [2:0]            sh;
    m = '0;
    for (int i = 0; i < 3; i++) begin
      s13_neg_nxt[i] = s12_t_r[i][T_W-1];
      mag[i] = s13_neg_nxt[i] ? MAG_W'(-$signed(s12_t_r[i])) : MAG_W'(s12_t_r[i]);
      if (mag[i] > m) begin
        m = mag[i];
      end
    end
    sh = 3'd7;
    for (int j = 7; j >= 0; j--) begin
      if ((m >> j) < (MAG_W'(1) << NL_W)) begin
        sh = 3'(j);
      end
    end
    for (int i = 0; i < 3; i++) begin
      s13_mag_nxt[i] = NL_W'(mag[i] >> sh);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s13_mag_r <= s13_mag_nxt;
      s13_neg_r <= s13_neg_nxt;
      s13_tir_r <= s12_tir_r;
    end
  end

  // stage 14: squares
  logic                 s14_vld_r;
  logic [2:0][NL_W-1:0] s14_mag_r;
  logic [2:0][SQ_W-1:0] s14_sq_r, s14_sq_nxt;
  logic [2:0]           s14_neg_r;
  logic                 s14_tir_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s14_sq_nxt[i] = SQ_W'(s13_mag_r[i]) * SQ_W'(s13_mag_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s14_mag_r <= s13_mag_r;
      s14_sq_r  <= s14_sq_nxt;
      s14_neg_r <= s13_neg_r;
      s14_tir_r <= s13_tir_r;
    end
  end

  // stage 15: squared length
  logic              s15_vld_r;
  pay_c_t            s15_pay_r, s15_pay_nxt;
  logic [LEN2_W-1:0] s15_len2_r, s15_len2_nxt;

  assign s15_len2_nxt = LEN2_W'(s14_sq_r[0]) + LEN2_W'(s14_sq_r[1]) + LEN2_W'(s14_sq_r[2]);
  assign s15_pay_nxt  = '{mag: s14_mag_r, neg: s14_neg_r, tir: s14_tir_r};

  always_ff @(posedge clk) begin
    if (en) begin
      s15_pay_r  <= s15_pay_nxt;
      s15_len2_r <= s15_len2_nxt;
    end
  end

  // length
  logic                      sc_vld;
  logic [ROOT_W-1:0]         sc_len;
  logic [$bits(pay_c_t)-1:0] sc_pay_raw;
  pay_c_t                    sc_pay;

  rdu_sqrt_pipe #(
    .ARG_W(ARG_W), .STEPS(4), .PAY_W($bits(pay_c_t))
  ) u_sqrt_len (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(s15_vld_r),
    .in_arg(ARG_W'(s15_len2_r)), .in_pay(s15_pay_r),
    .out_vld(sc_vld), .out_root(sc_len), .out_pay(sc_pay_raw)
  );
  assign sc_pay = sc_pay_raw;

  // stage 16: normalizing numerators and divisor
  logic                   s16_vld_r;
  logic [2:0][ONUM_W-1:0] s16_num_r, s16_num_nxt;
  logic [LDEN_W-1:0]      s16_den_r;
  pay_d_t                 s16_pay_r, s16_pay_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s16_num_nxt[i] = (ONUM_W'(sc_pay.mag[i]) << OQ_W) + ONUM_W'(sc_len);
    end
    s16_pay_nxt = '{neg: sc_pay.neg, tir: sc_pay.tir, zero: (sc_len == '0)};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s16_num_r <= s16_num_nxt;
      s16_den_r <= {sc_len, 1'b0};
      s16_pay_r <= s16_pay_nxt;
    end
  end

  // normalizing divider
  logic                      dd_vld;
  logic [2:0][OQ_W-1:0]      dd_q;
  logic [$bits(pay_d_t)-1:0] dd_pay_raw;
  pay_d_t                    dd_pay;

  rdu_div_pipe #(
    .LANES(3), .NUM_W(ONUM_W), .DEN_W(LDEN_W), .Q_W(OQ_W), .STEPS(4),
    .PAY_W($bits(pay_d_t))
  ) u_div_norm (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(s16_vld_r),
    .in_num(s16_num_r), .in_den(s16_den_r), .in_pay(s16_pay_r),
    .out_vld(dd_vld), .out_q(dd_q), .out_pay(dd_pay_raw)
  );
  assign dd_pay = dd_pay_raw;

  // output register
  logic     out_valid_r;
  rdu_out_t out_data_r, out_data_nxt;

  always_comb begin
    logic [2:0][VW-1:0] v;
    logic [1:0]         st;
    if (dd_pay.tir) begin
      st = ST_TIR;
    end else if (dd_pay.zero) begin
      st = ST_DEGENERATE;
    end else begin
      st = ST_REFRACTED;
    end
    for (int i = 0; i < 3; i++) begin
      if (st != ST_REFRACTED) begin
        v[i] = '0;
      end else if (dd_pay.neg[i]) begin
        v[i] = -VW'(dd_q[i]);
      end else begin
        v[i] = VW'(dd_q[i]);
      end
    end
    out_data_nxt.refracted_x    = v[0];
    out_data_nxt.refracted_y    = v[1];
    out_data_nxt.refracted_z    = v[2];
    out_data_nxt.refract_status = st;
  end

  assign out_load = !out_valid_r || !out_stall;
  assign en       = out_load || !dd_vld;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= dd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      s7_vld_r  <= 1'b0;
      s8_vld_r  <= 1'b0;
      s9_vld_r  <= 1'b0;
      s10_vld_r <= 1'b0;
      s11_vld_r <= 1'b0;
      s12_vld_r <= 1'b0;
      s13_vld_r <= 1'b0;
      s14_vld_r <= 1'b0;
      s15_vld_r <= 1'b0;
      s16_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= in_valid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= da_vld;
      s6_vld_r  <= s5_vld_r;
      s7_vld_r  <= s6_vld_r;
      s8_vld_r  <= s7_vld_r;
      s9_vld_r  <= s8_vld_r;
      s10_vld_r <= sb_vld;
      s11_vld_r <= s10_vld_r;
      s12_vld_r <= s11_vld_r;
      s13_vld_r <= s12_vld_r;
      s14_vld_r <= s13_vld_r;
      s15_vld_r <= s14_vld_r;
      s16_vld_r <= sc_vld;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
